>>> rtl/core/twr_pkg.sv
`timescale 1ns / 1ps
package twr_pkg;

  localparam int ANCHOR_SLOTS = 4;
  localparam int STAMP_BITS   = 40;

  localparam int SLOT_W  = (ANCHOR_SLOTS > 1) ? $clog2(ANCHOR_SLOTS) : 1;
  localparam int PROD_W  = 2 * STAMP_BITS;
  localparam int DEN_W   = STAMP_BITS + 2;
  // 2 * speed of light in m/s, and ticks per second scaled to mm
  localparam int LIGHT_W = 30;
  localparam int TICK_W  = 26;
  localparam logic [LIGHT_W-1:0] LIGHT2   = LIGHT_W'(599405094);
  localparam logic [TICK_W-1:0]  TICK_DEN = TICK_W'(63897600);
  localparam int NUM_W   = PROD_W + LIGHT_W;
  localparam int DM_W    = DEN_W + TICK_W;
  localparam int N_W     = NUM_W + 1;
  localparam int D_W     = DM_W + 1;
  localparam int Q_W     = 41;
  localparam logic [Q_W-1:0] DIST_CLAMP = {1'b1, {(Q_W-1){1'b0}}};
  localparam int CNT_W   = $clog2(STAMP_BITS + LIGHT_W);
  localparam int DCNT_W  = $clog2(Q_W);

  typedef enum logic {
    REG_TAG_ADDRESS   = 1'b0,
    REG_ANTENNA_DELAY = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOKUP, ST_MUL1, ST_MAG, ST_MUL2, ST_SUM, ST_START, ST_DIV, ST_FIN
  } state_e;

  typedef struct packed {
    logic [15:0]           anchor_addr;
    logic [STAMP_BITS-1:0] tag_tx_time;
    logic [STAMP_BITS-1:0] anchor_rx_time;
    logic [STAMP_BITS-1:0] anchor_tx_time;
    logic [STAMP_BITS-1:0] tag_rx_time;
    logic [7:0]            exchange_sequence;
    logic [7:0]            slot_number;
    logic [7:0]            flags_in;
    logic [14:0]           preamble_count;
    logic [7:0]            retries;
  } twr_in_t;

  typedef struct packed {
    logic [15:0]        result_anchor;
    logic [15:0]        result_tag;
    logic [7:0]         result_sequence;
    logic [7:0]         result_slot;
    logic [7:0]         result_flags;
    logic signed [31:0] distance_mm;
    logic [14:0]        quality;
    logic [7:0]         result_retries;
  } twr_out_t;

  typedef struct packed {
    logic                  hit;
    logic                  found;
    logic [SLOT_W-1:0]     idx;
    logic [STAMP_BITS-1:0] last_tx;
    logic [STAMP_BITS-1:0] last_rx;
  } twr_lookup_t;

endpackage

>>> rtl/core/twr_slot_table.sv
`timescale 1ns / 1ps
module twr_slot_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [15:0]                    anchor_i,
  input  logic                           wr_i,
  input  logic [twr_pkg::STAMP_BITS-1:0] tx_i,
  input  logic [twr_pkg::STAMP_BITS-1:0] rx_i,
  output twr_pkg::twr_lookup_t           lookup_o
);
  import twr_pkg::*;

  logic [ANCHOR_SLOTS-1:0] valid_q, valid_d;
  logic [15:0]             anchor_q [ANCHOR_SLOTS];
  logic [STAMP_BITS-1:0]   tx_q     [ANCHOR_SLOTS];
  logic [STAMP_BITS-1:0]   rx_q     [ANCHOR_SLOTS];
  logic                    hit, free;
  logic [SLOT_W-1:0]       hit_idx, free_idx, idx;

  // first matching slot, else first free slot
  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < ANCHOR_SLOTS; i++) begin
      if (!hit && valid_q[i] && anchor_q[i] == anchor_i) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!free && !valid_q[i]) begin
        free     = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign idx = hit ? hit_idx : free_idx;

  always_comb begin
    lookup_o.hit     = hit;
    lookup_o.found   = hit | free;
    lookup_o.idx     = idx;
    lookup_o.last_tx = tx_q[hit_idx];
    lookup_o.last_rx = rx_q[hit_idx];
  end

  always_comb begin
    valid_d = valid_q;
    if (wr_i && !hit && free) valid_d[free_idx] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i && (hit || free)) begin
      anchor_q[idx] <= anchor_i;
      tx_q[idx]     <= tx_i;
      rx_q[idx]     <= rx_i;
    end
  end

endmodule

>>> rtl/core/twr_serial_div.sv
`timescale 1ns / 1ps
module twr_serial_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [twr_pkg::N_W-1:0] num_i,
  input  logic [twr_pkg::D_W-1:0] den_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic [twr_pkg::Q_W-1:0] quot_o
);
  import twr_pkg::*;

  localparam int CMP_W = N_W + D_W + Q_W;

  logic              busy_q, busy_d, done_q, done_d, ovf_q, ovf_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [D_W-1:0]    rem_q, rem_d, den_q, den_d;
  logic [Q_W-1:0]    nq_q, nq_d;
  logic [N_W-1:0]    num_sh;
  logic [D_W:0]      trial, diff;
  logic              ge;

  assign num_sh = num_i >> Q_W;
  assign trial  = {rem_q, nq_q[Q_W-1]};
  assign diff   = trial - {1'b0, den_q};
  assign ge     = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    nq_d   = nq_q;
    if (start_i) begin
      // quotient at or above 2^Q_W saturates anyway
      ovf_d  = CMP_W'(num_i) >= (CMP_W'(den_i) << Q_W);
      rem_d  = num_sh[D_W-1:0];
      nq_d   = num_i[Q_W-1:0];
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[D_W-1:0] : trial[D_W-1:0];
      nq_d  = {nq_q[Q_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DCNT_W'(Q_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf_q <= ovf_d;
    rem_q <= rem_d;
    den_q <= den_d;
    nq_q  <= nq_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = (ovf_q || nq_q > DIST_CLAMP) ? DIST_CLAMP : nq_q;

endmodule

>>> rtl/core/twr_range_calculator.sv
`timescale 1ns / 1ps
// Channel | Signals                        | Direction | Transfer
// in      | in_valid_i in_ready_o in_data_i  | input     | valid & ready
// out     | out_valid_o out_ready_i out_data_o | output  | valid & ready
// cfg     | cfg_we_i cfg_index_i cfg_data_i  | input     | we high
//
// One exchange at a time. Double-sided: two 40-step bit-serial products,
// a 30-step scaling product and a 41-step restoring divide.
// Single-sided: the scaling product and the divide.
// Rejected exchanges free the input again straight from lookup.
// A finished result sits in the output register; the next exchange is
// taken while it waits, and only the final write waits for it.
// Reset clears the anchor slot valid bits, configuration and control.
module twr_range_calculator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  twr_pkg::twr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output twr_pkg::twr_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [15:0]       cfg_data_i
);
  import twr_pkg::*;

  localparam int SB = STAMP_BITS;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // configuration
  logic [15:0] tag_addr_q, delay_q;

  // held exchange
  twr_in_t     in_q;

  // arithmetic
  logic [SB-1:0]     ra_q, ra_d, da_q, da_d;
  logic [PROD_W-1:0] pp_q, pp_d, pn_q, pn_d, mag_q, mag_d;
  logic              neg_q, neg_d, ds_q, ds_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [NUM_W-1:0]  p2_q, p2_d;
  logic [DM_W-1:0]   p3_q, p3_d;
  logic [N_W-1:0]    n_q, n_d;

  logic              out_valid_q, out_valid_d;
  twr_out_t          out_q, out_d;

  twr_lookup_t       lk;
  logic              slot_wr;

  logic [SB-1:0]     ra, da, rb, db, ss_diff;
  logic [DEN_W-1:0]  den_sum;
  logic [SB:0]       sp, sn;
  logic [PROD_W:0]   s2;
  logic [DEN_W:0]    s3;
  logic [PROD_W-1:0] p_m_n, n_m_p;
  logic              div_start, div_busy, div_done;
  logic [Q_W-1:0]    quot;
  logic signed [42:0] dist_s, dist_v;

  twr_slot_table u_slots (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .anchor_i (in_q.anchor_addr),
    .wr_i     (slot_wr),
    .tx_i     (in_q.anchor_tx_time),
    .rx_i     (in_q.tag_rx_time),
    .lookup_o (lk)
  );

  twr_serial_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (n_q),
    .den_i   ({p3_q, 1'b0}),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // timestamp intervals, wrapping at the stamp width
  assign ra = in_q.anchor_rx_time - lk.last_tx;
  assign da = in_q.tag_tx_time - lk.last_rx;
  assign rb = in_q.tag_rx_time - in_q.tag_tx_time;
  assign db = in_q.anchor_tx_time - in_q.anchor_rx_time;
  assign den_sum = DEN_W'(ra) + DEN_W'(rb) + DEN_W'(da) + DEN_W'(db);
  assign ss_diff = rb - db;

  // shift-add steps: the multiplier sits in the low bits of the product
  assign sp = {1'b0, pp_q[PROD_W-1:SB]} + (pp_q[0] ? {1'b0, ra_q} : '0);
  assign sn = {1'b0, pn_q[PROD_W-1:SB]} + (pn_q[0] ? {1'b0, da_q} : '0);
  assign s2 = {1'b0, p2_q[NUM_W-1:LIGHT_W]} + (p2_q[0] ? {1'b0, mag_q} : '0);
  assign s3 = {1'b0, p3_q[DM_W-1:TICK_W]} + (p3_q[0] ? {1'b0, den_q} : '0);
  assign p_m_n = pp_q - pn_q;
  assign n_m_p = pn_q - pp_q;

  // sign, antenna delay, 32-bit saturation
  assign dist_s = neg_q ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
  assign dist_v = dist_s - 43'(signed'(delay_q));

  assign in_ready_o = (state_q == ST_IDLE);
  assign slot_wr    = (state_q == ST_LOOKUP) && (in_q.tag_tx_time != '0);
  assign div_start  = (state_q == ST_START);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ra_d        = ra_q;
    da_d        = da_q;
    pp_d        = pp_q;
    pn_d        = pn_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    ds_d        = ds_q;
    den_d       = den_q;
    p2_d        = p2_q;
    p3_d        = p3_q;
    n_d         = n_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cnt_d = '0;
        p2_d  = {{PROD_W{1'b0}}, LIGHT2};
        p3_d  = {{DEN_W{1'b0}}, TICK_DEN};
        if (in_q.tag_tx_time == '0) begin
          state_d = ST_IDLE;
        end else if (lk.hit) begin
          // all intervals zero means round equals reply: no range
          ra_d    = ra;
          da_d    = da;
          pp_d    = PROD_W'(rb);
          pn_d    = PROD_W'(db);
          den_d   = den_sum;
          ds_d    = 1'b1;
          state_d = (den_sum != '0) ? ST_MUL1 : ST_IDLE;
        end else begin
          mag_d   = PROD_W'(ss_diff >> 1);
          den_d   = DEN_W'(1);
          neg_d   = 1'b0;
          ds_d    = 1'b0;
          state_d = (rb > db) ? ST_MUL2 : ST_IDLE;
        end
      end
      ST_MUL1: begin
        pp_d  = {sp, pp_q[SB-1:1]};
        pn_d  = {sn, pn_q[SB-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SB - 1)) state_d = ST_MAG;
      end
      ST_MAG: begin
        neg_d   = pp_q < pn_q;
        mag_d   = (pp_q < pn_q) ? n_m_p : p_m_n;
        cnt_d   = '0;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        p2_d  = {s2, p2_q[LIGHT_W-1:1]};
        if (cnt_q < CNT_W'(TICK_W)) p3_d = {s3, p3_q[TICK_W-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(LIGHT_W - 1)) state_d = ST_SUM;
      end
      ST_SUM: begin
        // den*tick added for round-to-nearest
        n_d     = N_W'(p2_q) + N_W'(p3_q);
        state_d = ST_START;
      end
      ST_START: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d               = 1'b1;
          out_d.result_anchor       = in_q.anchor_addr;
          out_d.result_tag          = tag_addr_q;
          out_d.result_sequence     = in_q.exchange_sequence;
          out_d.result_slot         = in_q.slot_number;
          out_d.result_flags        = {in_q.flags_in[7:1], in_q.flags_in[0] | ds_q};
          out_d.quality             = in_q.preamble_count;
          out_d.result_retries      = in_q.retries;
          if (dist_v > 43'sd2147483647) begin
            out_d.distance_mm = 32'sh7FFF_FFFF;
          end else if (dist_v < -43'sd2147483648) begin
            out_d.distance_mm = 32'sh8000_0000;
          end else begin
            out_d.distance_mm = dist_v[31:0];
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      tag_addr_q  <= '0;
      delay_q     <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_TAG_ADDRESS:   tag_addr_q <= cfg_data_i;
          REG_ANTENNA_DELAY: delay_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    ra_q  <= ra_d;
    da_q  <= da_d;
    pp_q  <= pp_d;
    pn_q  <= pn_d;
    mag_q <= mag_d;
    neg_q <= neg_d;
    ds_q  <= ds_d;
    den_q <= den_d;
    p2_q  <= p2_d;
    p3_q  <= p3_d;
    n_q   <= n_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ST_LOOKUP)
    else $error("accepted exchange did not enter lookup");
  a_div_done_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_done) |=> state_q == ST_FIN)
    else $error("divider result not taken");
  a_fin_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> !div_busy)
    else $error("finishing while divider still busy");
  a_mag_ds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAG) |-> ds_q)
    else $error("double-sided path without hit");
  a_start_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> div_busy)
    else $error("divider did not start");
`endif

endmodule
